// ----- sv/assert_macros.svh -----
// Assertion macros used by the top level of the record header parser.
// Depends on a clock named clk and an active-low reset named rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge while the block is out of reset.
`define DRHP_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that the consequent holds in the clock cycle after the antecedent was seen.
`define DRHP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/drhp_pkg.sv -----
// Package for the device record header parser: beat types, phase codes and status codes.
// No dependencies; the parser top level and drhp_step import it.
package drhp_pkg;

    // Fixed header layout.
    localparam logic [7:0] MAGIC_0  = 8'h57;
    localparam logic [7:0] MAGIC_1  = 8'h56;
    localparam logic [7:0] MAGIC_2  = 8'h44;
    localparam logic [3:0] MIN_SIZE = 4'd8;

    localparam logic [7:0] VER_ONE  = 8'd1;
    localparam logic [7:0] VER_TWO  = 8'd2;
    localparam logic [7:0] TYPE_ONE = 8'd1;
    localparam logic [7:0] TYPE_TWO = 8'd2;

    // Byte positions inside the header.
    localparam logic [3:0] HDR_MAGIC0  = 4'd0;
    localparam logic [3:0] HDR_MAGIC1  = 4'd1;
    localparam logic [3:0] HDR_MAGIC2  = 4'd2;
    localparam logic [3:0] HDR_VERSION = 4'd3;
    localparam logic [3:0] HDR_TYPE    = 4'd4;
    localparam logic [3:0] HDR_LEVEL   = 4'd5;
    localparam logic [3:0] HDR_FLAGS   = 4'd6;

    // Section tags.
    localparam logic [1:0] SEC_NONE  = 2'd0;
    localparam logic [1:0] SEC_KEY   = 2'd1;
    localparam logic [1:0] SEC_IDENT = 2'd2;

    // Status codes.
    localparam logic [3:0] ST_BUSY    = 4'd0;
    localparam logic [3:0] ST_OK      = 4'd1;
    localparam logic [3:0] ST_SMALL   = 4'd2;
    localparam logic [3:0] ST_MAGIC   = 4'd3;
    localparam logic [3:0] ST_VERSION = 4'd4;
    localparam logic [3:0] ST_TYPE    = 4'd5;
    localparam logic [3:0] ST_TR_KLEN = 4'd6;
    localparam logic [3:0] ST_TR_KEY  = 4'd7;
    localparam logic [3:0] ST_TR_ILEN = 4'd8;
    localparam logic [3:0] ST_TR_ID   = 4'd9;

    typedef enum logic [3:0] {
        PH_HEADER  = 4'd0,
        PH_KLEN_LO = 4'd1,
        PH_KLEN_HI = 4'd2,
        PH_KEY     = 4'd3,
        PH_ILEN_LO = 4'd4,
        PH_ILEN_HI = 4'd5,
        PH_ID      = 4'd6,
        PH_TRAIL   = 4'd7,
        PH_DRAIN   = 4'd8
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_final;
    } item_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [1:0] section;
        logic       section_end;
        logic       device_kind;
        logic [7:0] level;
        logic [3:0] status;
    } result_t;

    // Parser context carried from one byte to the next.
    typedef struct packed {
        phase_t      phase;
        logic [3:0]  header_count;
        logic [15:0] remaining;
        logic [7:0]  length_low;
        logic        version_two;
        logic [3:0]  pending_error;
        logic        kind;
        logic [7:0]  level;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:         PH_HEADER,
        header_count:  4'd0,
        remaining:     16'd0,
        length_low:    8'd0,
        version_two:   1'b0,
        pending_error: ST_BUSY,
        kind:          1'b0,
        level:         8'd0
    };

endpackage

// ----- sv/device_record_header_parser_unit.sv -----
// Top level of the device record header parser: context register and output skid stage.
// Depends on drhp_pkg, drhp_step and assert_macros.svh.
//
// The parser takes one record byte per beat and gives exactly one result beat per input
// beat, so a steady stream runs at one byte per cycle while unstalled. The byte is
// checked against the magic and version fields, the type and security level are decoded,
// and key and identity bytes come out with a section tag and an end marker on the last
// byte of each section; header, length and trailing bytes come out with section zero.
// The status is busy on every beat but the final one, which carries the outcome of the
// whole record, and after which the parser is ready for a new record at once. The rate is
// set by the single context register that holds the parse phase and the length counter:
// each accepted byte updates it. Results pass through a result register backed by a
// one-entry skid register, so the input stalls only once two results are held.
module device_record_header_parser_unit
    import drhp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

`include "assert_macros.svh"

    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      step_res;

    logic    main_valid_reg;
    logic    main_valid_next;
    result_t main_reg;
    result_t main_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t skid_reg;
    result_t skid_next;

    logic accept;
    logic out_take;

    drhp_step u_step (
        .cur  (state_reg),
        .item (item),
        .nxt  (state_next),
        .res  (step_res)
    );

    // The skid register fills only while the result register is held, so the
    // input has to wait only while the skid register is occupied.
    assign item_stall   = skid_valid_reg;
    assign accept       = item_valid && !item_stall;
    assign out_take     = main_valid_reg && !result_stall;
    assign result_valid = main_valid_reg;
    assign result       = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_next       = main_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;

        if (out_take)
        begin
            if (skid_valid_reg)
            begin
                // Accept is blocked here, so the held result simply moves up.
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (accept)
            begin
                main_next = step_res;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (main_valid_reg)
            begin
                skid_next       = step_res;
                skid_valid_next = 1'b1;
            end
            else
            begin
                main_next       = step_res;
                main_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    // The skid register never holds a result while the result register is empty.
    `DRHP_ASSERT(a_skid_behind_main, skid_valid_reg |-> main_valid_reg, "skid holds data ahead of main")

    // The final byte of a record always leaves a fresh context behind.
    `DRHP_ASSERT_NEXT(a_restart_after_final, accept && item.is_final, state_reg == STATE_RESET, "no restart after final byte")

    // The context moves only when a byte is taken.
    `DRHP_ASSERT_NEXT(a_state_holds, !accept, $stable(state_reg), "context changed without a byte")

    // An end marker only ever rides on a key or identity byte.
    `DRHP_ASSERT(a_end_in_section, main_valid_reg && main_reg.section_end |-> main_reg.section != SEC_NONE, "section end outside a section")

endmodule

// ----- sv/drhp_step.sv -----
// Per-byte next-state and result logic of the device record header parser.
// Depends on drhp_pkg for the beat, state and code definitions.
module drhp_step
    import drhp_pkg::*;
(
    input  parse_state_t cur,
    input  item_t        item,
    output parse_state_t nxt,
    output result_t      res
);

    logic [7:0]  b;
    logic [15:0] rem_dec;
    logic [15:0] len;

    always_comb
    begin
        b       = item.data_byte;
        rem_dec = cur.remaining - 16'd1;
        len     = {b, cur.length_low};
        nxt     = cur;
        res     = '0;

        if (cur.header_count < MIN_SIZE)
        begin
            nxt.header_count = cur.header_count + 4'd1;
        end

        unique case (cur.phase)
            PH_HEADER:
            begin
                unique case (cur.header_count)
                    HDR_MAGIC0:
                    begin
                        if (b != MAGIC_0)
                        begin
                            nxt.pending_error = ST_MAGIC;
                            nxt.phase         = PH_DRAIN;
                        end
                    end
                    HDR_MAGIC1:
                    begin
                        if (b != MAGIC_1)
                        begin
                            nxt.pending_error = ST_MAGIC;
                            nxt.phase         = PH_DRAIN;
                        end
                    end
                    HDR_MAGIC2:
                    begin
                        if (b != MAGIC_2)
                        begin
                            nxt.pending_error = ST_MAGIC;
                            nxt.phase         = PH_DRAIN;
                        end
                    end
                    HDR_VERSION:
                    begin
                        if (b == VER_ONE)
                        begin
                            nxt.version_two = 1'b0;
                        end
                        else if (b == VER_TWO)
                        begin
                            nxt.version_two = 1'b1;
                        end
                        else
                        begin
                            nxt.pending_error = ST_VERSION;
                            nxt.phase         = PH_DRAIN;
                        end
                    end
                    HDR_TYPE:
                    begin
                        if (b == TYPE_ONE)
                        begin
                            nxt.kind = 1'b0;
                        end
                        else if (b == TYPE_TWO)
                        begin
                            nxt.kind = 1'b1;
                        end
                        else
                        begin
                            nxt.pending_error = ST_TYPE;
                            nxt.phase         = PH_DRAIN;
                        end
                    end
                    HDR_LEVEL:
                    begin
                        nxt.level = b;
                    end
                    HDR_FLAGS:
                    begin
                        // Version 2 records carry one padding byte after the flags.
                        if (!cur.version_two)
                        begin
                            nxt.phase = PH_KLEN_LO;
                        end
                    end
                    default:
                    begin
                        nxt.phase = PH_KLEN_LO;
                    end
                endcase
            end
            PH_KLEN_LO:
            begin
                nxt.length_low = b;
                nxt.phase      = PH_KLEN_HI;
            end
            PH_ILEN_LO:
            begin
                nxt.length_low = b;
                nxt.phase      = PH_ILEN_HI;
            end
            PH_KLEN_HI:
            begin
                nxt.remaining = len;
                nxt.phase     = (len != 16'd0) ? PH_KEY : PH_ILEN_LO;
            end
            PH_ILEN_HI:
            begin
                nxt.remaining = len;
                nxt.phase     = (len != 16'd0) ? PH_ID : PH_TRAIL;
            end
            PH_KEY:
            begin
                res.section      = SEC_KEY;
                res.payload_byte = b;
                nxt.remaining    = rem_dec;
                if (rem_dec == 16'd0)
                begin
                    res.section_end = 1'b1;
                    nxt.phase       = PH_ILEN_LO;
                end
            end
            PH_ID:
            begin
                res.section      = SEC_IDENT;
                res.payload_byte = b;
                nxt.remaining    = rem_dec;
                if (rem_dec == 16'd0)
                begin
                    res.section_end = 1'b1;
                    nxt.phase       = PH_TRAIL;
                end
            end
            default:
            begin
                // Trailing bytes and bytes after an error are dropped.
            end
        endcase

        res.device_kind = nxt.kind;
        res.level       = nxt.level;
        res.status      = ST_BUSY;

        if (item.is_final)
        begin
            if (nxt.header_count < MIN_SIZE)
            begin
                res.status = ST_SMALL;
            end
            else
            begin
                unique case (nxt.phase) inside
                    PH_DRAIN:                          res.status = cur.pending_error |
                                                                    nxt.pending_error;
                    PH_HEADER, PH_KLEN_LO, PH_KLEN_HI: res.status = ST_TR_KLEN;
                    PH_KEY:                            res.status = ST_TR_KEY;
                    PH_ILEN_LO, PH_ILEN_HI:            res.status = ST_TR_ILEN;
                    PH_ID:                             res.status = ST_TR_ID;
                    default:                           res.status = ST_OK;
                endcase
            end
            nxt = STATE_RESET;
        end
    end

endmodule
